### design/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LEN_REG_W  = 15;
    localparam int STORE_W    = 20;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'd1;

    // Register reset values.
    localparam logic [LEN_REG_W-1:0] DELAY_LENGTH_RESET  = 15'd14400;
    localparam logic [GAIN_W-1:0]    FEEDBACK_GAIN_RESET = 16'd32768;

    localparam int MAX_DELAY_DEFAULT = 16384;

    // Access strobes from the pipeline control to the delay memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

### design/fcr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fcr_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### design/fcr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fcr_pkg::SAMPLE_W-1:0]  pcm_out;

    modport source (output valid, output pcm_out, input ready);
    modport sink (input valid, input pcm_out, output ready);
endinterface

`default_nettype wire

### design/fcr_delay_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_delay_mem #(
    parameter int MAX_DELAY = fcr_pkg::MAX_DELAY_DEFAULT,
    parameter int AW        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1,
    parameter int LW        = $clog2(MAX_DELAY + 1)
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  fcr_pkg::mem_ctl_t                   ctl,
    input  wire  [AW-1:0]                       rd_addr,
    input  wire  [AW-1:0]                       wr_addr,
    input  wire  signed [fcr_pkg::STORE_W-1:0]  wr_data,
    output logic signed [fcr_pkg::STORE_W-1:0]  rd_data
);

    logic signed [fcr_pkg::STORE_W-1:0] mem [MAX_DELAY];
    logic signed [fcr_pkg::STORE_W-1:0] ram_q_reg;
    logic signed [fcr_pkg::STORE_W-1:0] fwd_data_reg;
    logic                               fwd_reg;
    logic                               fwd_next;
    logic                               known_reg;
    logic                               known_next;
    logic [LW-1:0]                      fill_reg;
    logic [LW-1:0]                      fill_next;

    // Entries are written in address order from zero, so the written set is
    // always a prefix; anything at or above the fill count still reads zero.
    assign known_next = (LW'(rd_addr) < fill_reg);
    assign fwd_next   = ctl.rd_en && ctl.wr_en && (rd_addr == wr_addr);

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.wr_en && (LW'(wr_addr) >= fill_reg))
        begin
            fill_next = LW'(wr_addr) + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            ram_q_reg <= mem[rd_addr];
        end
        if (fwd_next)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            fwd_reg   <= 1'b0;
            known_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (ctl.rd_en)
            begin
                fwd_reg   <= fwd_next;
                known_reg <= known_next;
            end
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (known_reg)
        begin
            rd_data = ram_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (LW'(wr_addr) <= fill_reg))
    else $error("write leaves a hole above the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(MAX_DELAY))
    else $error("fill count beyond the memory depth");

endmodule

`default_nettype wire

### design/fcr_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_mac (
    input  wire                                  clk,
    input  wire                                  load,
    input  wire  signed [fcr_pkg::STORE_W-1:0]   entry,
    input  wire  [fcr_pkg::GAIN_W-1:0]           gain,
    input  wire  signed [fcr_pkg::SAMPLE_W-1:0]  dry,
    output logic signed [fcr_pkg::STORE_W-1:0]   store_val,
    output logic signed [fcr_pkg::SAMPLE_W-1:0]  pcm_val
);

    localparam int PROD_W = fcr_pkg::STORE_W + fcr_pkg::GAIN_W + 1;
    localparam int BIAS_W = PROD_W + 1;
    localparam int RND_W  = BIAS_W - 16;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [SUM_W-1:0] STORE_HI = SUM_W'((1 << (fcr_pkg::STORE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] STORE_LO = -SUM_W'(1 << (fcr_pkg::STORE_W - 1));
    localparam logic signed [SUM_W-1:0] PCM_HI   = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] PCM_LO   = -SUM_W'(32767);

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [BIAS_W-1:0] biased;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;

    assign prod_next = PROD_W'(entry) * PROD_W'($signed({1'b0, gain}));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Q4.31 to Q4.15: add half an LSB, then floor by dropping 16 bits.
    assign biased = BIAS_W'(prod_reg) + BIAS_W'(32768);
    assign rnd    = biased[BIAS_W-1:16];
    assign sum    = SUM_W'(rnd) + SUM_W'(dry);

    always_comb
    begin
        if (sum > STORE_HI)
        begin
            store_val = STORE_HI[fcr_pkg::STORE_W-1:0];
        end
        else if (sum < STORE_LO)
        begin
            store_val = STORE_LO[fcr_pkg::STORE_W-1:0];
        end
        else
        begin
            store_val = sum[fcr_pkg::STORE_W-1:0];
        end

        if (sum > PCM_HI)
        begin
            pcm_val = PCM_HI[fcr_pkg::SAMPLE_W-1:0];
        end
        else if (sum < PCM_LO)
        begin
            pcm_val = PCM_LO[fcr_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            pcm_val = sum[fcr_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/feedback_comb_reverb.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role   Payload               Notes
// dry       sink   sample_in (s16 Q1.15) dry mono sample in
// wet       source pcm_out   (s16)       wet sample, clamped to +-32767
// cfg_*     write  cfg_index, cfg_data   delay_length (0), feedback_gain (1)
//
// An item passes the memory read and gain multiply and then the add,
// saturation and write-back; a new item is accepted only once the older one
// writes back. The write-back of one item can land with the read of the next;
// a bypass covers the same entry. The result reaches wet through the output register.
// Reset clears control state only; a fill count stands in for a memory clear.
// A stalled wet channel holds one item in the output register and one more.

module feedback_comb_reverb #(
    parameter int MAX_DELAY = fcr_pkg::MAX_DELAY_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    fcr_in_if.sink                             dry,
    fcr_out_if.source                          wet,
    input  wire                                cfg_we,
    input  wire  [fcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [fcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int CW = (LW > fcr_pkg::LEN_REG_W) ? LW : fcr_pkg::LEN_REG_W;

    // Configuration registers.
    logic [fcr_pkg::LEN_REG_W-1:0] len_reg;
    logic [fcr_pkg::GAIN_W-1:0]    gain_reg;

    // Position and pipeline control.
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic          b_valid_reg;
    logic          c_valid_reg;
    logic          out_valid_reg;

    // Pipeline payload.
    logic signed [fcr_pkg::SAMPLE_W-1:0] dry_b_reg;
    logic signed [fcr_pkg::SAMPLE_W-1:0] dry_c_reg;
    logic [AW-1:0]                       addr_b_reg;
    logic [AW-1:0]                       addr_c_reg;
    logic signed [fcr_pkg::SAMPLE_W-1:0] pcm_reg;

    logic [CW-1:0]   len_eff;
    logic [AW-1:0]   pos_eff;
    logic [CW-1:0]   pos_inc;
    logic            accept;
    logic            c_move;
    logic            out_take;

    fcr_pkg::mem_ctl_t                   mem_ctl;
    logic signed [fcr_pkg::STORE_W-1:0]  entry;
    logic signed [fcr_pkg::STORE_W-1:0]  store_val;
    logic signed [fcr_pkg::SAMPLE_W-1:0] pcm_val;

    // A length of zero acts as one; a length past the memory depth is capped.
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (CW'(len_reg) > CW'(MAX_DELAY))
        begin
            len_eff = CW'(MAX_DELAY);
        end
        else
        begin
            len_eff = CW'(len_reg);
        end
    end

    assign pos_eff  = (CW'(pos_reg) >= len_eff) ? '0 : pos_reg;
    assign pos_inc  = CW'(pos_eff) + CW'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

    // The write stage drains into the output register when that register is
    // empty or being emptied in the same cycle.
    assign out_take  = out_valid_reg && wet.ready;
    assign c_move    = c_valid_reg && (!out_valid_reg || wet.ready);

    // A new item enters only when the multiply stage is free and every older
    // item has written back by this edge, so the bypass in the memory sees
    // every pending update.
    assign dry.ready = !b_valid_reg && (!c_valid_reg || c_move);
    assign accept    = dry.valid && dry.ready;

    assign mem_ctl.rd_en = accept;
    assign mem_ctl.wr_en = c_move;

    fcr_delay_mem #(
        .MAX_DELAY (MAX_DELAY),
        .AW        (AW),
        .LW        (LW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (pos_eff),
        .wr_addr (addr_c_reg),
        .wr_data (store_val),
        .rd_data (entry)
    );

    fcr_mac u_mac (
        .clk       (clk),
        .load      (b_valid_reg),
        .entry     (entry),
        .gain      (gain_reg),
        .dry       (dry_c_reg),
        .store_val (store_val),
        .pcm_val   (pcm_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= fcr_pkg::DELAY_LENGTH_RESET;
            gain_reg      <= fcr_pkg::FEEDBACK_GAIN_RESET;
            pos_reg       <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == fcr_pkg::REG_DELAY_LENGTH))
            begin
                len_reg <= cfg_data[fcr_pkg::LEN_REG_W-1:0];
                pos_reg <= '0;
            end
            else if (accept)
            begin
                pos_reg <= pos_next;
            end

            if (cfg_we && (cfg_index == fcr_pkg::REG_FEEDBACK_GAIN))
            begin
                gain_reg <= cfg_data[fcr_pkg::GAIN_W-1:0];
            end

            b_valid_reg <= accept;
            c_valid_reg <= b_valid_reg || (c_valid_reg && !c_move);

            if (c_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dry_b_reg  <= dry.sample_in;
            addr_b_reg <= pos_eff;
        end
        if (b_valid_reg)
        begin
            dry_c_reg  <= dry_b_reg;
            addr_c_reg <= addr_b_reg;
        end
        if (c_move)
        begin
            pcm_reg <= pcm_val;
        end
    end

    assign wet.valid   = out_valid_reg;
    assign wet.pcm_out = pcm_reg;

    // The multiply stage always hands its item to the write stage at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |=> !b_valid_reg && c_valid_reg)
    else $error("multiply stage did not advance");

    // At most one item is between read and write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(b_valid_reg && c_valid_reg))
    else $error("two items in flight before write-back");

    // A blocked write stage keeps its item and its entry address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !c_move) |=> c_valid_reg && $stable(addr_c_reg))
    else $error("write stage lost its item while blocked");

    // The position stays inside the delay length in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (CW'(pos_reg) < len_eff))
    else $error("position beyond the delay length");

endmodule

`default_nettype wire

### dv/feedback_comb_reverb_tb.sv
`timescale 1ns / 1ps

module feedback_comb_reverb_tb;

    // Delay memory depth of the block under test (its parameter is left at default).
    localparam int MAX_TAPS = fcr_pkg::MAX_DELAY_DEFAULT;

    // Saturation limits: the 20-bit Q4.15 store and the symmetric 16-bit output.
    localparam longint STORE_MAX = (longint'(1) <<< (fcr_pkg::STORE_W - 1)) - 1;
    localparam longint STORE_MIN = -(longint'(1) <<< (fcr_pkg::STORE_W - 1));
    localparam longint PCM_LIMIT = 32767;

    localparam int RESULT_LATENCY = 2;

    // Any legal run finishes well inside this limit.
    localparam int CYCLE_LIMIT = 600000;

    // Length of the receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_OFF_CYCLES = 200;

    typedef logic signed [fcr_pkg::SAMPLE_W-1:0] sample_t;

    // Kinds of sample run that the random stimulus strings together.
    typedef enum int {
        RUN_NOISE,
        RUN_LOUD,
        RUN_QUIET
    } run_kind_t;

    // The comb filter predictor and the queue of expected output samples. Its
    // delay line, position and register copies follow the block item by item.
    class comb_scoreboard;
        logic signed [fcr_pkg::STORE_W-1:0] taps [MAX_TAPS];
        int unsigned                        position;
        logic [fcr_pkg::LEN_REG_W-1:0]      length_reg;
        logic [fcr_pkg::GAIN_W-1:0]         gain_reg;
        sample_t                            pcm_expected [$];
        int unsigned                        mismatches;
        int unsigned                        results_seen;

        function new();
            foreach (taps[i])
                taps[i] = '0;
            position     = 0;
            length_reg   = fcr_pkg::DELAY_LENGTH_RESET;
            gain_reg     = fcr_pkg::FEEDBACK_GAIN_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return pcm_expected.size();
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // A length write drops the upper data bit and sends the position home.
        // A gain write touches nothing else.
        function void write_register(input logic [fcr_pkg::CFG_IDX_W-1:0] index,
                                     input logic [fcr_pkg::CFG_DATA_W-1:0] value);
            if (index == fcr_pkg::REG_DELAY_LENGTH)
            begin
                length_reg = value[fcr_pkg::LEN_REG_W-1:0];
                position   = 0;
            end
            else if (index == fcr_pkg::REG_FEEDBACK_GAIN)
            begin
                gain_reg = value[fcr_pkg::GAIN_W-1:0];
            end
        endfunction

        // One dry sample in: read the tap, scale it, add, store saturated,
        // advance, and queue the clamped output sample.
        function void note_sample(input sample_t dry);
            int unsigned span;
            longint      product;
            longint      total;
            longint      stored;
            longint      pcm;

            // A zero length acts as one; anything past the memory depth is cut to it.
            span = length_reg;
            if (span < 1)
                span = 1;
            if (span > MAX_TAPS)
                span = MAX_TAPS;
            if (position >= span)
                position = 0;

            // Q4.15 times Q0.16, rounded back to Q4.15 with ties going upward.
            product = longint'(taps[position]) * longint'(gain_reg);
            total   = longint'(dry) + ((product + 32768) >>> 16);

            stored = total;
            if (stored > STORE_MAX)
                stored = STORE_MAX;
            if (stored < STORE_MIN)
                stored = STORE_MIN;
            taps[position] = stored[fcr_pkg::STORE_W-1:0];

            position = (position + 1 >= span) ? 0 : position + 1;

            pcm = total;
            if (pcm > PCM_LIMIT)
                pcm = PCM_LIMIT;
            if (pcm < -PCM_LIMIT)
                pcm = -PCM_LIMIT;
            pcm_expected.insert(pcm_expected.size(), pcm[fcr_pkg::SAMPLE_W-1:0]);
        endfunction

        task check_pcm(input sample_t got);
            sample_t want;

            if (pcm_expected.size() == 0)
            begin
                report($sformatf("pcm_out %0d arrived with no sample outstanding", got));
            end
            else
            begin
                want = pcm_expected[0];
                pcm_expected.delete(0);
                if (got !== want)
                    report($sformatf("output sample %0d: pcm_out %0d, expected %0d",
                                     results_seen, got, want));
            end
            results_seen++;
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fcr_pkg::CFG_DATA_W-1:0] cfg_data;

    fcr_in_if  dry_ch ();
    fcr_out_if wet_ch ();

    comb_scoreboard sb;

    // Idle rates in percent for the sample sender and the output receiver.
    int send_idle_pct;
    int recv_idle_pct;

    // The main thread asks for a hold-off here; the receiver counts it down itself.
    int hold_off_request;

    // State of the current run of random samples.
    int        run_left;
    run_kind_t run_kind;
    bit        run_negative;

    int cycle_count = 0;

    feedback_comb_reverb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .dry       (dry_ch),
        .wet       (wet_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost output sample ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("feedback_comb_reverb_tb: FAIL");
            $finish;
        end
    end

    // Output receiver. Every accepted output sample goes to the scoreboard;
    // ready then follows the current idle rate, or stays low through a hold-off.
    // Handshake signals are read right after the edge, so they hold the values
    // that the edge itself saw.
    initial
    begin
        int hold_off_left;

        hold_off_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && wet_ch.valid && wet_ch.ready)
                sb.check_pcm(wet_ch.pcm_out);
            if (hold_off_request != 0)
            begin
                hold_off_left    = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_off_left > 0)
            begin
                wet_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                wet_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one dry sample, after a random idle gap, and hold it until the
    // block takes it. Valid stays high when the next item follows at once.
    task automatic send_sample(input sample_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            dry_ch.valid <= 1'b0;
            @(posedge clk);
        end
        dry_ch.valid     <= 1'b1;
        dry_ch.sample_in <= value;
        @(posedge clk);
        while (!dry_ch.ready)
            @(posedge clk);
        sb.note_sample(value);
    endtask

    // Stop offering items and wait until every expected output sample is in,
    // then give the pipeline time to settle. Always waits on a clock edge
    // first, so valid is never lowered and raised in the same step.
    task automatic wait_for_results();
        dry_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (2 * RESULT_LATENCY)
            @(posedge clk);
    endtask

    task automatic put_register(input logic [fcr_pkg::CFG_IDX_W-1:0] index,
                                input logic [fcr_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(index, value);
    endtask

    // Registers are only written once the block has gone idle. The length
    // write is optional so that a lone gain write keeps the position.
    task automatic configure(input bit set_length,
                             input logic [fcr_pkg::CFG_DATA_W-1:0] length_word,
                             input logic [fcr_pkg::CFG_DATA_W-1:0] gain_word);
        wait_for_results();
        if (set_length)
            put_register(fcr_pkg::REG_DELAY_LENGTH, length_word);
        put_register(fcr_pkg::REG_FEEDBACK_GAIN, gain_word);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random samples come in runs: full-range noise, loud runs of one polarity
    // that drive the store into saturation at high gain, and quiet runs.
    function automatic sample_t draw_sample();
        logic [fcr_pkg::SAMPLE_W-1:0] magnitude;

        if (run_left == 0)
        begin
            run_left     = $urandom_range(40, 1);
            run_kind     = run_kind_t'($urandom_range(2));
            run_negative = 1'($urandom_range(1));
        end
        run_left--;
        case (run_kind)
            RUN_NOISE:
                return fcr_pkg::SAMPLE_W'($urandom);
            RUN_LOUD:
            begin
                magnitude = fcr_pkg::SAMPLE_W'($urandom_range(32767, 24576));
                return run_negative ? fcr_pkg::SAMPLE_W'(-int'(magnitude) - 1) : magnitude;
            end
            default:
                return fcr_pkg::SAMPLE_W'(int'($urandom_range(511)) - 256);
        endcase
    endfunction

    // Pick a random setting: mostly short delays so that the feedback path
    // is exercised, with gains leaning toward the top of the range.
    task automatic random_setting();
        logic [fcr_pkg::CFG_DATA_W-1:0] length_word;
        logic [fcr_pkg::CFG_DATA_W-1:0] gain_word;

        case ($urandom_range(9))
            0:       length_word = fcr_pkg::CFG_DATA_W'($urandom);
            1, 2:    length_word = fcr_pkg::CFG_DATA_W'($urandom_range(64, 9));
            default: length_word = fcr_pkg::CFG_DATA_W'($urandom_range(8, 1));
        endcase
        if ($urandom_range(1) == 1)
            gain_word = fcr_pkg::CFG_DATA_W'($urandom_range(65535, 57344));
        else
            gain_word = fcr_pkg::CFG_DATA_W'($urandom);
        configure($urandom_range(3) != 0, length_word, gain_word);
    endtask

    // One stretch of random samples. A squeezed stretch first has the
    // receiver hold off long enough for the block to back up into its input,
    // and later has the sender pause until the block has drained.
    task automatic random_stretch(input int count, input bit squeeze);
        for (int i = 0; i < count; i++)
        begin
            if (squeeze && i == count / 3)
                hold_off_request = HOLD_OFF_CYCLES;
            if (squeeze && i == 2 * count / 3)
                wait_for_results();
            send_sample(draw_sample());
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 3; k++)
        begin
            random_setting();
            random_stretch(150, k == 0);
        end
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = fcr_pkg::REG_DELAY_LENGTH;
        cfg_data         = '0;
        dry_ch.valid     = 1'b0;
        dry_ch.sample_in = '0;
        wet_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_off_request = 0;
        run_left         = 0;
        run_kind         = RUN_NOISE;
        run_negative     = 1'b0;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the long default delay means the output is the dry
        // sample, and the extremes of the input show the symmetric clamp.
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        // A zero length acts as a single tap; zero gain passes the dry sample.
        configure(1'b1, 16'd0, 16'd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);

        // Half gain on one tap: odd stored values land exactly on a rounding
        // tie, which must round upward for both signs.
        configure(1'b1, 16'd1, 16'd32768);
        send_sample(-16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd3);

        // A length past the memory depth is cut to the depth; full gain.
        configure(1'b1, 16'd32767, 16'd65535);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd12345);

        // The top data bit is not part of the length, so this is a length of two.
        configure(1'b1, 16'h8002, 16'd65535);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);

        // A gain write alone must leave the position where it was.
        configure(1'b0, 16'd0, 16'd49152);
        send_sample(16'sd100);
        send_sample(-16'sd100);

        // Random stimulus under the three idle patterns.
        random_phase(37, 55);
        random_phase(55, 37);
        random_phase(0, 0);

        wait_for_results();

        if (sb.mismatches == 0)
            $display("feedback_comb_reverb_tb: PASS");
        else
            $display("feedback_comb_reverb_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
design/fcr_pkg.sv
design/fcr_in_if.sv
design/fcr_out_if.sv
design/fcr_delay_mem.sv
design/fcr_mac.sv
design/feedback_comb_reverb.sv
dv/feedback_comb_reverb_tb.sv
